// ----- src/mcsc_pkg.sv -----
// ----------------------------------------------------------------------------
// mcsc_pkg
// shared types and constants of the multi-camera sync checker
// ----------------------------------------------------------------------------
package mcsc_pkg;

   localparam int CAM_INPUTS      = 3;
   localparam int NUM_CAMERAS_DEF = 3;
   localparam int MIN_PRESENT_DEF = 2;

   localparam int TS_W    = 64;
   localparam int FRAME_W = 32;
   localparam int TOL_W   = 32;
   localparam int COUNT_W = 2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNCONFIG = 2'd1;
   localparam logic [1:0] STATUS_FEW      = 2'd2;
   localparam logic [1:0] STATUS_SPREAD   = 2'd3;

   typedef struct packed {
      logic               present;
      logic [TS_W-1:0]    timestamp;
      logic [FRAME_W-1:0] frame;
   } cam_type;

   // running result handed from cell to cell
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TS_W-1:0]    lo;
      logic [TS_W-1:0]    hi;
      logic               drop;
   } agg_type;

   typedef struct packed {
      cam_type [CAM_INPUTS-1:0] cams;
      agg_type                  agg;
   } stage_type;

   typedef struct packed {
      logic               accepted;
      logic [1:0]         status;
      logic [TS_W-1:0]    trigger_timestamp;
      logic [TS_W-1:0]    spread_ns;
      logic [COUNT_W-1:0] present_count;
      logic               frame_drop;
   } rsp_type;

endpackage

// ----- src/mcsc_req_if.sv -----
// ----------------------------------------------------------------------------
// mcsc_req_if
// capture round channel, one item per round of three cameras
// ----------------------------------------------------------------------------
interface mcsc_req_if;
   logic        valid;
   logic        ready;
   logic        cam_a_present;
   logic [63:0] cam_a_timestamp;
   logic [31:0] cam_a_frame;
   logic        cam_b_present;
   logic [63:0] cam_b_timestamp;
   logic [31:0] cam_b_frame;
   logic        cam_c_present;
   logic [63:0] cam_c_timestamp;
   logic [31:0] cam_c_frame;

   modport source (
      output valid, cam_a_present, cam_a_timestamp, cam_a_frame,
             cam_b_present, cam_b_timestamp, cam_b_frame,
             cam_c_present, cam_c_timestamp, cam_c_frame,
      input  ready
   );

   modport sink (
      input  valid, cam_a_present, cam_a_timestamp, cam_a_frame,
             cam_b_present, cam_b_timestamp, cam_b_frame,
             cam_c_present, cam_c_timestamp, cam_c_frame,
      output ready
   );
endinterface

// ----- src/mcsc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mcsc_rsp_if
// sync result channel, one item per capture round
// ----------------------------------------------------------------------------
interface mcsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [1:0]  status;
   logic [63:0] trigger_timestamp;
   logic [63:0] spread_ns;
   logic [1:0]  present_count;
   logic        frame_drop;

   modport source (
      output valid, accepted, status, trigger_timestamp, spread_ns,
             present_count, frame_drop,
      input  ready
   );

   modport sink (
      input  valid, accepted, status, trigger_timestamp, spread_ns,
             present_count, frame_drop,
      output ready
   );
endinterface

// ----- src/mcsc_cell.sv -----
// ----------------------------------------------------------------------------
// mcsc_cell
// one camera cell: frame sequence check and running min/max of timestamps
// ----------------------------------------------------------------------------
module mcsc_cell
   import mcsc_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   logic               valid_ff, valid_in;
   stage_type          data_ff, data_in;
   logic [FRAME_W-1:0] last_frame_ff, last_frame_in;
   logic               last_valid_ff, last_valid_in;
   logic               take;
   cam_type            cam;
   agg_type            agg;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign cam      = in_data.cams[IDX];

   always_comb begin
      agg = in_data.agg;
      if (cam.present) begin
         if (agg.count == '0) begin
            agg.lo = cam.timestamp;
            agg.hi = cam.timestamp;
         end else begin
            if (cam.timestamp < agg.lo) agg.lo = cam.timestamp;
            if (cam.timestamp > agg.hi) agg.hi = cam.timestamp;
         end
         agg.count = agg.count + COUNT_W'(1);
         if (last_valid_ff && (cam.frame != last_frame_ff + FRAME_W'(1))) begin
            agg.drop = 1'b1;
         end
      end
   end

   always_comb begin
      valid_in      = valid_ff;
      data_in       = data_ff;
      last_frame_in = last_frame_ff;
      last_valid_in = last_valid_ff;
      if (take) begin
         valid_in      = 1'b1;
         data_in.cams  = in_data.cams;
         data_in.agg   = agg;
         last_valid_in = cam.present;
         if (cam.present) last_frame_in = cam.frame;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         last_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         last_valid_ff <= last_valid_in;
      end
      data_ff       <= data_in;
      last_frame_ff <= last_frame_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- src/mcsc_judge.sv -----
// ----------------------------------------------------------------------------
// mcsc_judge
// count check, spread against tolerance, output register
// ----------------------------------------------------------------------------
module mcsc_judge
   import mcsc_pkg::*;
#(
   parameter int MIN_PRESENT = MIN_PRESENT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [TOL_W-1:0] tolerance,
   input  logic             in_valid,
   output logic             in_ready,
   input  agg_type          in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rsp_type          out_data
);

   localparam logic [3:0] MinPresentW = 4'(MIN_PRESENT);

   logic            valid_ff, valid_in;
   rsp_type         rsp_ff, rsp_in;
   rsp_type         res;
   logic [TS_W-1:0] spread;
   logic            take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign spread   = in_data.hi - in_data.lo;

   always_comb begin
      res.accepted          = 1'b0;
      res.status            = STATUS_FEW;
      res.trigger_timestamp = '0;
      res.spread_ns         = '0;
      res.present_count     = in_data.count;
      res.frame_drop        = in_data.drop;
      if ({2'b00, in_data.count} >= MinPresentW) begin
         res.spread_ns = spread;
         if (tolerance == '0) begin
            res.status            = STATUS_UNCONFIG;
            res.accepted          = 1'b1;
            res.trigger_timestamp = in_data.hi;
         end else if (spread > {{(TS_W-TOL_W){1'b0}}, tolerance}) begin
            res.status = STATUS_SPREAD;
         end else begin
            res.status            = STATUS_OK;
            res.accepted          = 1'b1;
            res.trigger_timestamp = in_data.hi;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (take) begin
         valid_in = 1'b1;
         rsp_in   = res;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

// ----- src/multi_camera_sync_checker_top.sv -----
// ----------------------------------------------------------------------------
// multi_camera_sync_checker_top
// Takes one capture round per item and returns one sync result per item.
// The rounds flow through a chain of camera cells, one register stage per
// camera (each cell keeps that camera's last frame number and valid mark),
// followed by the output register. One item is accepted every cycle unless
// back-pressure from the result channel stalls the chain. When enough cameras
// are present, a zero tolerance skips the spread check and reports the
// unconfigured status.
// ----------------------------------------------------------------------------
module multi_camera_sync_checker_top
   import mcsc_pkg::*;
#(
   parameter int NUM_CAMERAS = NUM_CAMERAS_DEF,
   parameter int MIN_PRESENT = MIN_PRESENT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   mcsc_req_if.sink         req_chan,
   mcsc_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [TOL_W-1:0] csr_wr_data
);

   localparam int NumCells = (NUM_CAMERAS < CAM_INPUTS) ? NUM_CAMERAS : CAM_INPUTS;

   logic [TOL_W-1:0] tolerance_ff, tolerance_in;
   logic             stage_valid [NumCells+1];
   logic             stage_ready [NumCells+1];
   stage_type        stage_data  [NumCells+1];
   rsp_type          rsp;

   assign tolerance_in = csr_wr_en ? csr_wr_data : tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= '0;
      end else begin
         tolerance_ff <= tolerance_in;
      end
   end

   assign stage_valid[0]                 = req_chan.valid;
   assign req_chan.ready                 = stage_ready[0];
   assign stage_data[0].cams[0].present   = req_chan.cam_a_present;
   assign stage_data[0].cams[0].timestamp = req_chan.cam_a_timestamp;
   assign stage_data[0].cams[0].frame     = req_chan.cam_a_frame;
   assign stage_data[0].cams[1].present   = req_chan.cam_b_present;
   assign stage_data[0].cams[1].timestamp = req_chan.cam_b_timestamp;
   assign stage_data[0].cams[1].frame     = req_chan.cam_b_frame;
   assign stage_data[0].cams[2].present   = req_chan.cam_c_present;
   assign stage_data[0].cams[2].timestamp = req_chan.cam_c_timestamp;
   assign stage_data[0].cams[2].frame     = req_chan.cam_c_frame;
   assign stage_data[0].agg               = '0;

   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      mcsc_cell #(
         .IDX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   mcsc_judge #(
      .MIN_PRESENT (MIN_PRESENT)
   ) u_judge (
      .clock     (clock),
      .reset     (reset),
      .tolerance (tolerance_ff),
      .in_valid  (stage_valid[NumCells]),
      .in_ready  (stage_ready[NumCells]),
      .in_data   (stage_data[NumCells].agg),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp)
   );

   assign rsp_chan.accepted          = rsp.accepted;
   assign rsp_chan.status            = rsp.status;
   assign rsp_chan.trigger_timestamp = rsp.trigger_timestamp;
   assign rsp_chan.spread_ns         = rsp.spread_ns;
   assign rsp_chan.present_count     = rsp.present_count;
   assign rsp_chan.frame_drop        = rsp.frame_drop;

endmodule
